[rtl/core/ite_pkg.sv]
package ite_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int TABLE_LEN       = 24;
    localparam int QB              = 24;
    localparam int ACC_SCALE_SH    = 8;

    localparam int ITER_W = $clog2(CORDIC_STEPS);
    localparam int XY_W   = 40;
    localparam int Z_W    = 36;
    localparam int ANG_W  = ANGLE_FRAC_BITS + 9;
    localparam int OP_W   = (ANG_W > 26) ? ANG_W + 1 : 27;
    localparam int ACC_W  = 2 * OP_W + 2;
    localparam int PC_W   = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W  = 16;
    localparam int OUT_W  = 17;

    localparam logic signed [OP_W-1:0] Q_ONE   = OP_W'(16777216);
    localparam logic signed [OP_W-1:0] Q_HALF  = OP_W'(8388608);
    localparam logic signed [OP_W-1:0] Q_SIN   = OP_W'(14529495);
    localparam logic signed [XY_W-1:0] Q_GAIN  = XY_W'(10188014);
    localparam logic signed [Z_W-1:0]  LIM_Z   = Z_W'(180) <<< QB;
    localparam logic signed [Z_W-1:0]  HALF_Z  = Z_W'(90) <<< QB;
    localparam logic signed [ACC_W-1:0] LIM_Q  = ACC_W'(180) <<< QB;
    localparam logic signed [ACC_W-1:0] LIM_F  = ACC_W'(180) <<< ANGLE_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] OUT_LIM = ACC_W'(46080);
    localparam logic signed [15:0] ONE_G = 16'sd16384;

    localparam logic [PC_W-1:0] PC_MOTOR = PC_W'(14);
    localparam logic [PC_W-1:0] PC_LAST  = PC_W'(25);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACC_OFF_X, REG_ACC_OFF_Y, REG_ACC_OFF_Z, REG_GYRO_OFF_X,
        REG_GYRO_OFF_Y, REG_GYRO_WEIGHT, REG_STEP_MS, REG_UPRIGHT_LIM
    } cfg_reg_t;

    typedef enum logic [1:0] {
        K_MAC, K_VEC, K_ROT
    } kind_t;

    typedef enum logic [4:0] {
        SRC_GX, SRC_GY, SRC_STEP, SRC_ANG, SRC_W, SRC_WC, SRC_ACCX, SRC_ACCY,
        SRC_CX, SRC_SNX, SRC_CY, SRC_SNY, SRC_R01, SRC_R02, SRC_R12, SRC_R20,
        SRC_R21, SRC_T01, SRC_T11, SRC_NH, SRC_SS, SRC_NSS
    } src_t;

    typedef enum logic [4:0] {
        DST_NONE, DST_ATX, DST_ATY, DST_INCY, DST_BLY, DST_INCX, DST_BLX,
        DST_SCX, DST_SCY, DST_R01, DST_R02, DST_R21, DST_R22, DST_T20,
        DST_T21, DST_T01, DST_T11, DST_M11, DST_M12, DST_ROLL
    } dst_t;

    typedef struct packed {
        kind_t kind;
        src_t  a_sel;
        src_t  b_sel;
        logic  first;
        logic  last;
        dst_t  dst;
    } uop_t;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic first;
    } mac_ctl_t;

    typedef struct packed {
        logic start;
        logic rotate;
    } cor_req_t;

    function automatic uop_t mk(input kind_t k, input src_t a, input src_t b,
                                input logic f, input logic l, input dst_t d);
        uop_t u;
        u.kind  = k;
        u.a_sel = a;
        u.b_sel = b;
        u.first = f;
        u.last  = l;
        u.dst   = d;
        return u;
    endfunction

    // sequencer program, motor section runs twice
    function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            5'd0:  u = mk(K_VEC, SRC_GX, SRC_GX, 1'b1, 1'b1, DST_ATX);
            5'd1:  u = mk(K_VEC, SRC_GX, SRC_GX, 1'b1, 1'b1, DST_ATY);
            5'd2:  u = mk(K_MAC, SRC_GY, SRC_STEP, 1'b1, 1'b1, DST_INCY);
            5'd3:  u = mk(K_MAC, SRC_ANG, SRC_W, 1'b1, 1'b0, DST_NONE);
            5'd4:  u = mk(K_MAC, SRC_ACCY, SRC_WC, 1'b0, 1'b1, DST_BLY);
            5'd5:  u = mk(K_MAC, SRC_GX, SRC_STEP, 1'b1, 1'b1, DST_INCX);
            5'd6:  u = mk(K_MAC, SRC_ANG, SRC_W, 1'b1, 1'b0, DST_NONE);
            5'd7:  u = mk(K_MAC, SRC_ACCX, SRC_WC, 1'b0, 1'b1, DST_BLX);
            5'd8:  u = mk(K_ROT, SRC_GX, SRC_GX, 1'b1, 1'b1, DST_SCX);
            5'd9:  u = mk(K_ROT, SRC_GX, SRC_GX, 1'b1, 1'b1, DST_SCY);
            5'd10: u = mk(K_MAC, SRC_SNY, SRC_SNX, 1'b1, 1'b1, DST_R01);
            5'd11: u = mk(K_MAC, SRC_SNY, SRC_CX, 1'b1, 1'b1, DST_R02);
            5'd12: u = mk(K_MAC, SRC_CY, SRC_SNX, 1'b1, 1'b1, DST_R21);
            5'd13: u = mk(K_MAC, SRC_CY, SRC_CX, 1'b1, 1'b1, DST_R22);
            5'd14: u = mk(K_MAC, SRC_NH, SRC_R20, 1'b1, 1'b0, DST_NONE);
            5'd15: u = mk(K_MAC, SRC_SS, SRC_R21, 1'b0, 1'b1, DST_T20);
            5'd16: u = mk(K_MAC, SRC_NSS, SRC_R20, 1'b1, 1'b0, DST_NONE);
            5'd17: u = mk(K_MAC, SRC_NH, SRC_R21, 1'b0, 1'b1, DST_T21);
            5'd18: u = mk(K_MAC, SRC_NSS, SRC_CY, 1'b1, 1'b0, DST_NONE);
            5'd19: u = mk(K_MAC, SRC_NH, SRC_R01, 1'b0, 1'b1, DST_T01);
            5'd20: u = mk(K_MAC, SRC_NH, SRC_CX, 1'b1, 1'b1, DST_T11);
            5'd21: u = mk(K_MAC, SRC_NSS, SRC_T01, 1'b1, 1'b0, DST_NONE);
            5'd22: u = mk(K_MAC, SRC_NH, SRC_T11, 1'b0, 1'b1, DST_M11);
            5'd23: u = mk(K_MAC, SRC_NSS, SRC_R02, 1'b1, 1'b0, DST_NONE);
            5'd24: u = mk(K_MAC, SRC_NH, SRC_R12, 1'b0, 1'b1, DST_M12);
            5'd25: u = mk(K_VEC, SRC_GX, SRC_GX, 1'b1, 1'b1, DST_ROLL);
            default: u = mk(K_MAC, SRC_GX, SRC_GX, 1'b1, 1'b1, DST_NONE);
        endcase
        return u;
    endfunction

    // atan(2^-i) in degrees, q24
    function automatic logic [31:0] atan_tab(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd754974720;
            5'd1:  v = 32'd445687602;
            5'd2:  v = 32'd235489088;
            5'd3:  v = 32'd119537938;
            5'd4:  v = 32'd60000934;
            5'd5:  v = 32'd30029717;
            5'd6:  v = 32'd15018523;
            5'd7:  v = 32'd7509720;
            5'd8:  v = 32'd3754917;
            5'd9:  v = 32'd1877466;
            5'd10: v = 32'd938734;
            5'd11: v = 32'd469367;
            5'd12: v = 32'd234684;
            5'd13: v = 32'd117342;
            5'd14: v = 32'd58671;
            5'd15: v = 32'd29335;
            5'd16: v = 32'd14668;
            5'd17: v = 32'd7334;
            5'd18: v = 32'd3667;
            5'd19: v = 32'd1833;
            5'd20: v = 32'd917;
            5'd21: v = 32'd458;
            5'd22: v = 32'd229;
            5'd23: v = 32'd115;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // add half an lsb, then floor shift
    function automatic logic signed [ACC_W-1:0] rsh(input logic signed [ACC_W-1:0] v,
                                                    input int s);
        logic signed [ACC_W-1:0] h;
        h = (s > 0) ? (ACC_W'(1) <<< (s - 1)) : '0;
        return (v + h) >>> s;
    endfunction

    function automatic logic signed [ACC_W-1:0] clampv(input logic signed [ACC_W-1:0] v,
                                                       input logic signed [ACC_W-1:0] lim);
        logic signed [ACC_W-1:0] r;
        if (v > lim)
            r = lim;
        else if (v < -lim)
            r = -lim;
        else
            r = v;
        return r;
    endfunction

endpackage

[rtl/core/ite_mac.sv]
module ite_mac
    import ite_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mac_ctl_t                ctl,
    input  logic signed [OP_W-1:0]  op_a,
    input  logic signed [OP_W-1:0]  op_b,
    output logic signed [ACC_W-1:0] acc
);

    logic signed [2*OP_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    always_comb
    begin
        if (ctl.first)
            acc_next = ACC_W'(prod_reg);
        else
            acc_next = acc_reg + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            if (ctl.mul_en)
                prod_reg <= op_a * op_b;
            if (ctl.acc_en)
                acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

[rtl/core/ite_cordic.sv]
module ite_cordic
    import ite_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cor_req_t               req,
    input  logic signed [XY_W-1:0] x_in,
    input  logic signed [XY_W-1:0] y_in,
    input  logic signed [Z_W-1:0]  z_in,
    output logic                   done,
    output logic signed [XY_W-1:0] x_out,
    output logic signed [XY_W-1:0] y_out,
    output logic signed [Z_W-1:0]  z_out
);

    typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cstate_t;

    cstate_t           state_reg;
    logic [ITER_W-1:0] iter_reg;
    logic              done_reg;
    logic              rot_reg;
    logic              neg_reg;
    logic signed [XY_W-1:0] x_reg, y_reg, xo_reg, yo_reg;
    logic signed [Z_W-1:0]  z_reg, zo_reg;

    logic signed [XY_W-1:0] xs, ys, x_next, y_next, x0, y0;
    logic signed [Z_W-1:0]  tab, z_next, z0, a_cl;
    logic                   up, hold, neg0;

    always_comb
    begin
        tab = Z_W'($signed({1'b0, atan_tab(5'(iter_reg))}));
        xs  = x_reg >>> iter_reg;
        ys  = y_reg >>> iter_reg;
        if (rot_reg)
        begin
            up   = ~z_reg[Z_W-1];
            hold = 1'b0;
        end
        else
        begin
            up   = y_reg[XY_W-1];
            hold = (y_reg == '0);
        end
        if (hold)
        begin
            x_next = x_reg;
            y_next = y_reg;
            z_next = z_reg;
        end
        else if (up)
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - tab;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + tab;
        end

        // start values: fold angle into +-90 deg, or mirror a left half-plane vector
        a_cl = z_in;
        if (z_in > LIM_Z)
            a_cl = LIM_Z;
        else if (z_in < -LIM_Z)
            a_cl = -LIM_Z;
        neg0 = 1'b0;
        x0 = x_in;
        y0 = y_in;
        z0 = '0;
        if (req.rotate)
        begin
            x0 = Q_GAIN;
            y0 = '0;
            z0 = a_cl;
            if (a_cl > HALF_Z)
            begin
                z0 = a_cl - LIM_Z;
                neg0 = 1'b1;
            end
            else if (a_cl < -HALF_Z)
            begin
                z0 = a_cl + LIM_Z;
                neg0 = 1'b1;
            end
        end
        else if (x_in[XY_W-1])
        begin
            x0 = -x_in;
            y0 = -y_in;
            z0 = y_in[XY_W-1] ? -LIM_Z : LIM_Z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            iter_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == C_FIN);
            case (state_reg)
                C_IDLE:
                begin
                    if (req.start)
                    begin
                        iter_reg  <= '0;
                        state_reg <= C_RUN;
                    end
                end
                C_RUN:
                begin
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITER_W'(CORDIC_STEPS - 1))
                        state_reg <= C_FIN;
                end
                C_FIN:
                begin
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == C_IDLE && req.start)
        begin
            x_reg   <= x0;
            y_reg   <= y0;
            z_reg   <= z0;
            rot_reg <= req.rotate;
            neg_reg <= neg0;
        end
        else if (state_reg == C_RUN)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
        if (state_reg == C_FIN)
        begin
            xo_reg <= neg_reg ? -x_reg : x_reg;
            yo_reg <= neg_reg ? -y_reg : y_reg;
            if (z_reg > LIM_Z)
                zo_reg <= LIM_Z;
            else if (z_reg < -LIM_Z)
                zo_reg <= -LIM_Z;
            else
                zo_reg <= z_reg;
        end
    end

    assign done  = done_reg;
    assign x_out = xo_reg;
    assign y_out = yo_reg;
    assign z_out = zo_reg;

endmodule

[rtl/core/imu_tilt_estimator_unit.sv]
// Tilt estimator: takes one raw IMU request, removes offsets, runs a
// complementary filter on the X/Y tilt and gives the roll seen by both motors.
// One request runs six CORDIC passes of 16 iterations on a single shared CORDIC
// plus 32 multiply-accumulate steps on one multiplier; in_ready is high only
// while the sequencer is idle. A finished result waits in the output register,
// so the next request is accepted while it is pending; a new result that finds
// the register still full holds the sequencer.
module imu_tilt_estimator_unit
    import ite_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [15:0]           accel_x,
    input  logic signed [15:0]           accel_y,
    input  logic signed [15:0]           accel_z,
    input  logic signed [15:0]           rate_x,
    input  logic signed [15:0]           rate_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [OUT_W-1:0]      tilt_x,
    output logic signed [OUT_W-1:0]      tilt_y,
    output logic signed [OUT_W-1:0]      roll_motor1,
    output logic signed [OUT_W-1:0]      roll_motor2,
    output logic                         upright
);

    typedef enum logic [2:0] {ST_IDLE, ST_FETCH, ST_ACC, ST_WB, ST_CORD, ST_DONE} state_t;

    state_t          state_reg;
    logic [PC_W-1:0] pc_reg;
    logic            motor_reg;
    logic            out_valid_reg;

    logic signed [15:0] acc_off_x_reg, acc_off_y_reg, acc_off_z_reg;
    logic signed [15:0] gyro_off_x_reg, gyro_off_y_reg;
    logic [15:0]        gyro_weight_reg;
    logic [7:0]         step_ms_reg;
    logic [15:0]        upright_lim_reg;

    logic signed [ANG_W-1:0] angle_x_reg, angle_y_reg;
    logic signed [ANG_W-1:0] a_reg, accx_reg, accy_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg;
    logic signed [OP_W-1:0] cx_reg, snx_reg, cy_reg, sny_reg;
    logic signed [OP_W-1:0] r01_reg, r02_reg, r21_reg, r22_reg;
    logic signed [OP_W-1:0] t20_reg, t21_reg, t01_reg, t11_reg, m11_reg, m12_reg;
    logic signed [OUT_W-1:0] roll1_reg, roll2_reg;
    logic signed [OUT_W-1:0] tilt_x_reg, tilt_y_reg, roll1_out_reg, roll2_out_reg;
    logic                    upright_reg;

    uop_t     uop;
    mac_ctl_t mac_ctl;
    cor_req_t cor_req;
    logic signed [OP_W-1:0]  op_a, op_b;
    logic signed [ACC_W-1:0] mac_acc;
    logic                    cor_done;
    logic signed [XY_W-1:0]  cor_x_in, cor_y_in, cor_x, cor_y;
    logic signed [Z_W-1:0]   cor_z_in, cor_z;

    logic gimbal;
    logic signed [ACC_W-1:0] inc_sum, blend_v, mat_v, tilt_v, roll_q, roll_v;
    logic signed [ACC_W-1:0] tx_v, ty_v, ab_tx, ab_ty, lim_v;
    logic [16:0] wc;
    logic step_adv, load_out;

    assign uop    = uop_at(pc_reg);
    assign gimbal = (t20_reg >= Q_ONE) || (t20_reg <= -Q_ONE);
    assign wc     = 17'h10000 - {1'b0, gyro_weight_reg};

    function automatic logic signed [OP_W-1:0] pick(input src_t s,
        input logic signed [15:0] gx, input logic signed [15:0] gy,
        input logic signed [ANG_W-1:0] ang, input logic signed [ANG_W-1:0] ax_t,
        input logic signed [ANG_W-1:0] ay_t, input logic [7:0] stp,
        input logic [15:0] w, input logic [16:0] wcv, input logic mot,
        input logic signed [OP_W-1:0] cx, input logic signed [OP_W-1:0] snx,
        input logic signed [OP_W-1:0] cy, input logic signed [OP_W-1:0] sny,
        input logic signed [OP_W-1:0] r01, input logic signed [OP_W-1:0] r02,
        input logic signed [OP_W-1:0] r21, input logic signed [OP_W-1:0] t01,
        input logic signed [OP_W-1:0] t11);
        logic signed [OP_W-1:0] v;
        case (s)
            SRC_GX:   v = OP_W'(gx);
            SRC_GY:   v = OP_W'(gy);
            SRC_STEP: v = OP_W'($signed({1'b0, stp}));
            SRC_ANG:  v = OP_W'(ang);
            SRC_W:    v = OP_W'($signed({1'b0, w}));
            SRC_WC:   v = OP_W'($signed({1'b0, wcv}));
            SRC_ACCX: v = OP_W'(ax_t);
            SRC_ACCY: v = OP_W'(ay_t);
            SRC_CX:   v = cx;
            SRC_SNX:  v = snx;
            SRC_CY:   v = cy;
            SRC_SNY:  v = sny;
            SRC_R01:  v = r01;
            SRC_R02:  v = r02;
            SRC_R12:  v = -snx;
            SRC_R20:  v = -sny;
            SRC_R21:  v = r21;
            SRC_T01:  v = t01;
            SRC_T11:  v = t11;
            SRC_NH:   v = -Q_HALF;
            SRC_SS:   v = mot ? -Q_SIN : Q_SIN;
            SRC_NSS:  v = mot ? Q_SIN : -Q_SIN;
            default:  v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        op_a = pick(uop.a_sel, gx_reg, gy_reg, a_reg, accx_reg, accy_reg, step_ms_reg,
                    gyro_weight_reg, wc, motor_reg, cx_reg, snx_reg, cy_reg, sny_reg,
                    r01_reg, r02_reg, r21_reg, t01_reg, t11_reg);
        op_b = pick(uop.b_sel, gx_reg, gy_reg, a_reg, accx_reg, accy_reg, step_ms_reg,
                    gyro_weight_reg, wc, motor_reg, cx_reg, snx_reg, cy_reg, sny_reg,
                    r01_reg, r02_reg, r21_reg, t01_reg, t11_reg);

        mac_ctl.mul_en = (state_reg == ST_FETCH) && (uop.kind == K_MAC);
        mac_ctl.acc_en = (state_reg == ST_ACC);
        mac_ctl.first  = uop.first;

        cor_req.start  = (state_reg == ST_FETCH) && (uop.kind != K_MAC);
        cor_req.rotate = (uop.kind == K_ROT);

        cor_x_in = XY_W'(az_reg) <<< ACC_SCALE_SH;
        cor_y_in = XY_W'(ay_reg) <<< ACC_SCALE_SH;
        cor_z_in = Z_W'(angle_x_reg) <<< (QB - ANGLE_FRAC_BITS);
        case (uop.dst)
            DST_ATY:  cor_y_in = XY_W'(ax_reg) <<< ACC_SCALE_SH;
            DST_SCY:  cor_z_in = Z_W'(angle_y_reg) <<< (QB - ANGLE_FRAC_BITS);
            DST_ROLL:
            begin
                cor_y_in = gimbal ? -XY_W'(m12_reg) : XY_W'(t21_reg);
                cor_x_in = gimbal ? XY_W'(m11_reg) : XY_W'(r22_reg);
            end
            default:  cor_x_in = cor_x_in;
        endcase

        // writeback values
        if (uop.dst == DST_INCX)
            inc_sum = ACC_W'(angle_x_reg) + rsh(mac_acc <<< ANGLE_FRAC_BITS, 16);
        else
            inc_sum = ACC_W'(angle_y_reg) + rsh(mac_acc <<< ANGLE_FRAC_BITS, 16);
        inc_sum = clampv(inc_sum, LIM_F);
        blend_v = clampv(rsh(mac_acc, 16), LIM_F);
        mat_v   = rsh(mac_acc, QB);
        tilt_v  = clampv(rsh(ACC_W'(cor_z), QB - ANGLE_FRAC_BITS), LIM_F);
        roll_q  = gimbal ? -ACC_W'(cor_z) : ACC_W'(cor_z);
        roll_v  = clampv(rsh(clampv(roll_q, LIM_Q), QB - 8), OUT_LIM);

        tx_v  = clampv(rsh(ACC_W'(angle_x_reg), ANGLE_FRAC_BITS - 8), OUT_LIM);
        ty_v  = clampv(rsh(ACC_W'(angle_y_reg), ANGLE_FRAC_BITS - 8), OUT_LIM);
        ab_tx = tx_v[ACC_W-1] ? -tx_v : tx_v;
        ab_ty = ty_v[ACC_W-1] ? -ty_v : ty_v;
        lim_v = ACC_W'($signed({1'b0, upright_lim_reg}));

        step_adv = ((state_reg == ST_ACC) && !uop.last) || (state_reg == ST_WB)
                   || ((state_reg == ST_CORD) && cor_done);
        load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    end

    ite_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .op_a  (op_a),
        .op_b  (op_b),
        .acc   (mac_acc)
    );

    ite_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cor_req),
        .x_in  (cor_x_in),
        .y_in  (cor_y_in),
        .z_in  (cor_z_in),
        .done  (cor_done),
        .x_out (cor_x),
        .y_out (cor_y),
        .z_out (cor_z)
    );

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_off_x_reg   <= '0;
            acc_off_y_reg   <= '0;
            acc_off_z_reg   <= '0;
            gyro_off_x_reg  <= '0;
            gyro_off_y_reg  <= '0;
            gyro_weight_reg <= 16'd65274;
            step_ms_reg     <= 8'd15;
            upright_lim_reg <= 16'd5120;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ACC_OFF_X:   acc_off_x_reg   <= cfg_data;
                REG_ACC_OFF_Y:   acc_off_y_reg   <= cfg_data;
                REG_ACC_OFF_Z:   acc_off_z_reg   <= cfg_data;
                REG_GYRO_OFF_X:  gyro_off_x_reg  <= cfg_data;
                REG_GYRO_OFF_Y:  gyro_off_y_reg  <= cfg_data;
                REG_GYRO_WEIGHT: gyro_weight_reg <= cfg_data;
                REG_STEP_MS:     step_ms_reg     <= cfg_data[7:0];
                REG_UPRIGHT_LIM: upright_lim_reg <= cfg_data;
                default:         step_ms_reg     <= step_ms_reg;
            endcase
        end
    end

    // sequencer and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            motor_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            angle_x_reg   <= '0;
            angle_y_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= load_out || (out_valid_reg && !out_ready);

            if (state_reg == ST_WB)
            begin
                if (uop.dst == DST_BLY)
                    angle_y_reg <= ANG_W'(blend_v);
                if (uop.dst == DST_BLX)
                    angle_x_reg <= ANG_W'(blend_v);
            end

            if (step_adv)
            begin
                if (pc_reg == PC_LAST)
                begin
                    if (!motor_reg)
                    begin
                        motor_reg <= 1'b1;
                        pc_reg    <= PC_MOTOR;
                        state_reg <= ST_FETCH;
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                else
                begin
                    pc_reg    <= pc_reg + 1'b1;
                    state_reg <= ST_FETCH;
                end
            end
            else
            begin
                case (state_reg)
                    ST_IDLE:
                    begin
                        if (in_valid)
                        begin
                            pc_reg    <= '0;
                            motor_reg <= 1'b0;
                            state_reg <= ST_FETCH;
                        end
                    end
                    ST_FETCH:
                    begin
                        state_reg <= (uop.kind == K_MAC) ? ST_ACC : ST_CORD;
                    end
                    ST_ACC:
                    begin
                        state_reg <= ST_WB;
                    end
                    ST_DONE:
                    begin
                        if (load_out)
                            state_reg <= ST_IDLE;
                    end
                    default:
                    begin
                        state_reg <= state_reg;
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            ax_reg <= accel_x - acc_off_x_reg;
            ay_reg <= accel_y - acc_off_y_reg;
            az_reg <= accel_z - acc_off_z_reg + ONE_G;
            gx_reg <= rate_x - gyro_off_x_reg;
            gy_reg <= rate_y - gyro_off_y_reg;
        end

        if (state_reg == ST_WB)
        begin
            case (uop.dst)
                DST_INCX, DST_INCY: a_reg   <= ANG_W'(inc_sum);
                DST_R01:            r01_reg <= OP_W'(mat_v);
                DST_R02:            r02_reg <= OP_W'(mat_v);
                DST_R21:            r21_reg <= OP_W'(mat_v);
                DST_R22:            r22_reg <= OP_W'(mat_v);
                DST_T20:            t20_reg <= OP_W'(mat_v);
                DST_T21:            t21_reg <= OP_W'(mat_v);
                DST_T01:            t01_reg <= OP_W'(mat_v);
                DST_T11:            t11_reg <= OP_W'(mat_v);
                DST_M11:            m11_reg <= OP_W'(mat_v);
                DST_M12:            m12_reg <= OP_W'(mat_v);
                default:            a_reg   <= a_reg;
            endcase
        end

        if (state_reg == ST_CORD && cor_done)
        begin
            case (uop.dst)
                DST_ATX: accx_reg <= ANG_W'(tilt_v);
                DST_ATY: accy_reg <= ANG_W'(-tilt_v);
                DST_SCX:
                begin
                    cx_reg  <= OP_W'(cor_x);
                    snx_reg <= OP_W'(cor_y);
                end
                DST_SCY:
                begin
                    cy_reg  <= OP_W'(cor_x);
                    sny_reg <= OP_W'(cor_y);
                end
                DST_ROLL:
                begin
                    if (motor_reg)
                        roll2_reg <= OUT_W'(roll_v);
                    else
                        roll1_reg <= OUT_W'(roll_v);
                end
                default: accx_reg <= accx_reg;
            endcase
        end

        if (load_out)
        begin
            tilt_x_reg    <= OUT_W'(tx_v);
            tilt_y_reg    <= OUT_W'(ty_v);
            roll1_out_reg <= roll1_reg;
            roll2_out_reg <= roll2_reg;
            upright_reg   <= (ab_tx < lim_v) && (ab_ty < lim_v);
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign tilt_x      = tilt_x_reg;
    assign tilt_y      = tilt_y_reg;
    assign roll_motor1 = roll1_out_reg;
    assign roll_motor2 = roll2_out_reg;
    assign upright     = upright_reg;

endmodule
